[sv/rational_normalizer_macros.svh]
// assertion macros used by the rational normaliser checker
`ifndef RATIONAL_NORMALIZER_MACROS_SVH
`define RATIONAL_NORMALIZER_MACROS_SVH

// clocked property that is switched off while reset is asserted
`define RN_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked property that is also checked around reset
`define RN_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/rn_pkg.sv]
// types and constants of the rational normaliser
`default_nettype none

package rn_pkg;

    localparam int STATUS_W = 2;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_ZERO_DEN = 2'd1;
    localparam t_status ST_OVERFLOW = 2'd2;

    // handshake state of the shared divider
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

[sv/rational_normalizer.sv]
// rational normaliser top level: sign handling, binary gcd and reduction by division
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata: num_in, den_in
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata: num_out, den_out; tuser: status
//
// one item at a time; a full reduction runs from accept to result in these steps:
// the gcd loop strips one bit or subtracts once per cycle,
// then the shared divider computes each of the two quotients in turn.
// zero numerator and the error cases skip the gcd loop and the divider.
// synchronous active-low reset clears the sequencer and the output valid.
// a stalled result waits in the output register; the next item is taken meanwhile.
`default_nettype none

module rational_normalizer #(
    parameter int WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [WIDTH-1:0] num_in, [2*WIDTH-1:WIDTH] den_in, zero padding above
    input  wire logic [((2*WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [WIDTH-1:0] num_out, [2*WIDTH-2:WIDTH] den_out, zero padding above
    output logic [((2*WIDTH+6)/8)*8-1:0] m_axis_tdata,
    // [1:0] status
    output logic [rn_pkg::STATUS_W-1:0] m_axis_tuser
);

    localparam int OUT_W = ((2*WIDTH+6)/8)*8;
    localparam logic [WIDTH-1:0] SIGN = {1'b1, {(WIDTH-1){1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_GCD  = 5'b00010,
        S_DIVN = 5'b00100,
        S_DIVD = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [WIDTH-1:0]   r_a, n_a;
    logic [WIDTH-1:0]   r_b, n_b;
    logic [WIDTH-1:0]   r_nq, n_nq;
    logic [WIDTH-1:0]   r_dq, n_dq;
    logic [WIDTH-1:0]   r_g, n_g;
    logic [WIDTH-1:0]   r_rn, n_rn;
    logic               r_neg, n_neg;
    logic               r_pos_cand, n_pos_cand;
    logic [WIDTH-1:0]   r_res_num, n_res_num;
    logic [WIDTH-2:0]   r_res_den, n_res_den;
    rn_pkg::t_status    r_res_st, n_res_st;
    logic               r_m_valid, n_m_valid;
    logic [WIDTH-1:0]   r_m_num, n_m_num;
    logic [WIDTH-2:0]   r_m_den, n_m_den;
    rn_pkg::t_status    r_m_st, n_m_st;

    logic [WIDTH-1:0]   w_n, w_d, w_nmag, w_dmag;
    logic [WIDTH-1:0]   w_g;
    logic               w_gcd_end;
    logic               w_div_start;
    logic [WIDTH-1:0]   w_dividend, w_divisor;
    rn_pkg::t_div_stat  w_div_stat;
    logic [WIDTH-1:0]   w_quotient;
    logic               w_in_fire;
    logic               w_out_free;

    assign w_n    = s_axis_tdata[WIDTH-1:0];
    assign w_d    = s_axis_tdata[2*WIDTH-1:WIDTH];
    assign w_nmag = w_n[WIDTH-1] ? (~w_n + 1'b1) : w_n;
    assign w_dmag = w_d[WIDTH-1] ? (~w_d + 1'b1) : w_d;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    // the loop ends once one operand reaches zero; the other one is the odd part of the gcd
    assign w_gcd_end = (r_a == '0) || (r_b == '0);
    assign w_g       = (r_a == '0) ? r_b : r_a;

    assign w_div_start = ((r_state == S_GCD) && w_gcd_end)
                      || ((r_state == S_DIVN) && w_div_stat.done);
    assign w_dividend  = (r_state == S_GCD) ? r_nq : r_dq;
    assign w_divisor   = (r_state == S_GCD) ? w_g : r_g;

    rn_divider #(
        .WIDTH      (WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_stat     (w_div_stat),
        .o_quotient (w_quotient)
    );

    always_comb begin
        n_state    = r_state;
        n_a        = r_a;
        n_b        = r_b;
        n_nq       = r_nq;
        n_dq       = r_dq;
        n_g        = r_g;
        n_rn       = r_rn;
        n_neg      = r_neg;
        n_pos_cand = r_pos_cand;
        n_res_num  = r_res_num;
        n_res_den  = r_res_den;
        n_res_st   = r_res_st;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_num    = r_m_num;
        n_m_den    = r_m_den;
        n_m_st     = r_m_st;

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_a        = w_nmag;
                    n_b        = w_dmag;
                    n_nq       = w_nmag;
                    n_dq       = w_dmag;
                    n_neg      = w_n[WIDTH-1] ^ w_d[WIDTH-1];
                    n_pos_cand = w_n[WIDTH-1] & w_d[WIDTH-1];
                    n_res_num  = '0;
                    n_res_den  = '0;
                    n_res_st   = rn_pkg::ST_OK;
                    if (w_d == '0) begin
                        n_res_st = rn_pkg::ST_ZERO_DEN;
                        n_state  = S_OUT;
                    end else if (w_d == SIGN) begin
                        n_res_st = rn_pkg::ST_OVERFLOW;
                        n_state  = S_OUT;
                    end else if (w_n == '0) begin
                        n_res_den = (WIDTH-1)'(1);
                        n_state   = S_OUT;
                    end else begin
                        n_state = S_GCD;
                    end
                end
            end
            S_GCD: begin
                if (w_gcd_end) begin
                    n_g     = w_g;
                    n_state = S_DIVN;
                end else if (!r_a[0] && !r_b[0]) begin
                    // common factor of two leaves the fraction as well
                    n_a  = r_a >> 1;
                    n_b  = r_b >> 1;
                    n_nq = r_nq >> 1;
                    n_dq = r_dq >> 1;
                end else if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (r_a >= r_b) begin
                    n_a = (r_a - r_b) >> 1;
                end else begin
                    n_b = (r_b - r_a) >> 1;
                end
            end
            S_DIVN: begin
                if (w_div_stat.done) begin
                    n_rn    = w_quotient;
                    n_state = S_DIVD;
                end
            end
            S_DIVD: begin
                if (w_div_stat.done) begin
                    // both signs negative with a magnitude of half the range cannot be positive
                    if (r_pos_cand && r_rn[WIDTH-1]) begin
                        n_res_num = '0;
                        n_res_den = '0;
                        n_res_st  = rn_pkg::ST_OVERFLOW;
                    end else begin
                        n_res_num = r_neg ? (~r_rn + 1'b1) : r_rn;
                        n_res_den = w_quotient[WIDTH-2:0];
                        n_res_st  = rn_pkg::ST_OK;
                    end
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_num   = r_res_num;
                    n_m_den   = r_res_den;
                    n_m_st    = r_res_st;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_nq       <= n_nq;
        r_dq       <= n_dq;
        r_g        <= n_g;
        r_rn       <= n_rn;
        r_neg      <= n_neg;
        r_pos_cand <= n_pos_cand;
        r_res_num  <= n_res_num;
        r_res_den  <= n_res_den;
        r_res_st   <= n_res_st;
        r_m_num    <= n_m_num;
        r_m_den    <= n_m_den;
        r_m_st     <= n_m_st;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_W'({r_m_den, r_m_num});
    assign m_axis_tuser  = r_m_st;

endmodule

`default_nettype wire

[sv/rn_divider.sv]
// restoring divider, one quotient bit per cycle
`default_nettype none

module rn_divider #(
    parameter int WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [WIDTH-1:0]   i_dividend,
    input  wire logic [WIDTH-1:0]   i_divisor,
    output rn_pkg::t_div_stat       o_stat,
    output logic [WIDTH-1:0]        o_quotient
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [WIDTH-1:0]   r_rem;
    logic [WIDTH-1:0]   r_quo;
    logic [WIDTH-1:0]   r_dvs;

    logic [WIDTH:0]     w_trial;
    logic [WIDTH:0]     w_diff;
    logic               w_qbit;
    logic [WIDTH-1:0]   n_rem;

    // trial subtract of the divisor from the shifted partial remainder
    always_comb begin
        w_trial = {r_rem, r_quo[WIDTH-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_qbit  = !w_diff[WIDTH];
        n_rem   = w_qbit ? w_diff[WIDTH-1:0] : w_trial[WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WIDTH - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[WIDTH-2:0], w_qbit};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

`default_nettype wire

[sv/rn_checker.sv]
// port-level checks of the rational normaliser and their bind
`default_nettype none

`include "rational_normalizer_macros.svh"

module rn_checker #(
    parameter int WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    input  wire logic                           s_axis_tready,
    // [WIDTH-1:0] num_in, [2*WIDTH-1:WIDTH] den_in, zero padding above
    input  wire logic [((2*WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [WIDTH-1:0] num_out, [2*WIDTH-2:WIDTH] den_out, zero padding above
    input  wire logic [((2*WIDTH+6)/8)*8-1:0]   m_axis_tdata,
    // [1:0] status
    input  wire logic [rn_pkg::STATUS_W-1:0]    m_axis_tuser
);

    logic w_in_fire;
    logic w_ok;

    assign w_in_fire = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);
    assign w_ok      = (m_axis_tuser == rn_pkg::ST_OK);

    // a waiting result holds still until taken
    `RN_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // a good result always has a nonzero denominator
    `RN_ASSERT(a_ok_den, i_clk, i_rst_n, m_axis_tvalid && w_ok |-> m_axis_tdata[WIDTH +: WIDTH-1] != '0, "zero denominator with good status")

    // an error result carries zero data
    `RN_ASSERT(a_err_zero, i_clk, i_rst_n, m_axis_tvalid && !w_ok |-> m_axis_tdata == '0, "error result with nonzero data")

    // an accepted item cannot produce a result in the very next cycle from an idle output
    `RN_ASSERT(a_no_instant, i_clk, i_rst_n, w_in_fire && !m_axis_tvalid |=> !m_axis_tvalid, "result appeared too early")

    // reset leaves no result on the output
    `RN_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind rational_normalizer rn_checker #(
    .WIDTH          (WIDTH)
) u_rn_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser)
);

`default_nettype wire

[verif/tb_top.sv]
// testbench for the rational normaliser: streamed fractions checked against a gcd reduction predictor
`default_nettype none

module tb_top;

    localparam int WIDTH      = 32;
    localparam int IN_W       = ((2*WIDTH+7)/8)*8;
    localparam int OUT_W      = ((2*WIDTH+6)/8)*8;
    localparam int N_RANDOM   = 830;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_LEN   = 400;
    localparam int TAIL_LEN   = 200;
    localparam logic [WIDTH-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [WIDTH-1:0] MOST_POS = 32'h7fff_ffff;

    typedef struct packed {
        logic [WIDTH-1:0] num;
        logic [WIDTH-2:0] den;
        rn_pkg::t_status  status;
    } t_fraction;

    class fraction_scoreboard;
        t_fraction pending_fractions[$];
        int        fail_count;

        function new();
            fail_count = 0;
        endfunction

        // sign fix-up, euclid on magnitudes, then reduction
        function t_fraction reduce_fraction(logic [WIDTH-1:0] n, logic [WIDTH-1:0] d);
            t_fraction        f;
            logic [WIDTH-1:0] nmag, dmag, a, b, r, rn, rd;
            logic             neg;
            f = '0;
            if (d == '0) begin
                f.status = rn_pkg::ST_ZERO_DEN;
            end else if (d == MOST_NEG) begin
                f.status = rn_pkg::ST_OVERFLOW;
            end else begin
                nmag = n[WIDTH-1] ? ('0 - n) : n;
                dmag = d[WIDTH-1] ? ('0 - d) : d;
                neg  = n[WIDTH-1] ^ d[WIDTH-1];
                a = nmag;
                b = dmag;
                while (b != '0) begin
                    r = a % b;
                    a = b;
                    b = r;
                end
                rn = nmag / a;
                rd = dmag / a;
                if (!neg && rn[WIDTH-1]) begin
                    f.status = rn_pkg::ST_OVERFLOW;
                end else begin
                    f.num    = neg ? ('0 - rn) : rn;
                    f.den    = rd[WIDTH-2:0];
                    f.status = rn_pkg::ST_OK;
                end
            end
            return f;
        endfunction

        function void note_input(logic [WIDTH-1:0] n, logic [WIDTH-1:0] d);
            pending_fractions.push_back(reduce_fraction(n, d));
        endfunction

        function void check_result(logic [OUT_W-1:0] tdata, rn_pkg::t_status tuser);
            t_fraction want;
            if (pending_fractions.size() == 0) begin
                $display("%0t: unexpected result num %h den %h status %0d",
                         $time, tdata[WIDTH-1:0], tdata[2*WIDTH-2:WIDTH], tuser);
                fail_count++;
                return;
            end
            want = pending_fractions.pop_front();
            if (tdata[WIDTH-1:0] !== want.num) begin
                $display("%0t: num_out expected %h actual %h",
                         $time, want.num, tdata[WIDTH-1:0]);
                fail_count++;
            end
            if (tdata[2*WIDTH-2:WIDTH] !== want.den) begin
                $display("%0t: den_out expected %h actual %h",
                         $time, want.den, tdata[2*WIDTH-2:WIDTH]);
                fail_count++;
            end
            if (tuser !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, tuser);
                fail_count++;
            end
        endfunction

        function int pending();
            return pending_fractions.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_W-1:0]         s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_W-1:0]        m_axis_tdata;
    logic [rn_pkg::STATUS_W-1:0] m_axis_tuser;

    fraction_scoreboard sb = new();
    int sent_count = 0;
    int recv_count = 0;

    always #10 i_clk = ~i_clk;

    rational_normalizer #(.WIDTH(WIDTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // offers one fraction and waits for its transaction; valid stays up for the next call
    task automatic send_fraction(input logic [WIDTH-1:0] n, input logic [WIDTH-1:0] d);
        int gap;
        gap = ((sent_count % 100) < 20) ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {d, n};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(n, d);
        sent_count++;
    endtask

    task automatic random_operands(output logic [WIDTH-1:0] n, output logic [WIDTH-1:0] d);
        int               pick;
        logic [WIDTH-1:0] g;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            n = $urandom;
            d = $urandom;
        end else if (pick < 65) begin
            // common factor so the reduction has work to do
            g = $urandom_range(1, 65535);
            n = g * $urandom_range(0, 4095);
            d = g * $urandom_range(1, 4095);
            if ($urandom_range(0, 1)) n = '0 - n;
            if ($urandom_range(0, 1)) d = '0 - d;
        end else if (pick < 80) begin
            n = $urandom_range(0, 1023) << $urandom_range(0, 20);
            d = $urandom_range(1, 1023) << $urandom_range(0, 20);
            if ($urandom_range(0, 1)) n = '0 - n;
            if ($urandom_range(0, 1)) d = '0 - d;
        end else if (pick < 87) begin
            // most negative numerator against odd and even denominators of either sign
            n = MOST_NEG;
            d = $urandom_range(1, 65536);
            if ($urandom_range(0, 1)) d = '0 - d;
        end else if (pick < 92) begin
            n = $urandom;
            d = '0;
        end else if (pick < 96) begin
            n = $urandom;
            d = MOST_NEG;
        end else begin
            n = '0;
            d = $urandom;
        end
    endtask

    // result side: random stalls, one long hold-off to back the block up
    initial begin : result_sink
        int  stall;
        bit  held;
        held = 1'b0;
        forever begin
            stall = ((recv_count % 90) < 15) ? 0 : $urandom_range(0, 5);
            if (recv_count == 60 && !held) begin
                held  = 1'b1;
                stall = HOLD_LEN;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata, m_axis_tuser);
            recv_count++;
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("** rational_normalizer: FAILED **");
        $finish;
    end

    initial begin : stimulus
        logic [WIDTH-1:0] dir_num[] = '{
            32'd0, 32'd0, 32'd0, 32'd5, MOST_NEG, 32'd0, 32'd1, MOST_NEG,
            MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS,
            MOST_POS, MOST_NEG + 1, 32'd6, -32'sd6, 32'd12, MOST_POS, 32'd1, -32'sd1,
            32'h4000_0000
        };
        logic [WIDTH-1:0] dir_den[] = '{
            32'd1, -32'sd1, MOST_NEG, 32'd0, 32'd0, 32'd0, MOST_NEG, MOST_NEG,
            -32'sd1, -32'sd3, 32'd1, 32'd3, -32'sd2, 32'd2, MOST_POS, -32'sd1,
            32'd1, MOST_NEG + 1, -32'sd4, 32'd4, 32'd18, MOST_NEG + 1, 32'd1, -32'sd1,
            32'h7fff_fffe
        };
        logic [WIDTH-1:0] n, d;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_num[i]) send_fraction(dir_num[i], dir_den[i]);
        repeat (N_RANDOM) begin
            random_operands(n, d);
            send_fraction(n, d);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_LEN) @(posedge i_clk);

        if (sb.fail_count == 0)
            $display("** rational_normalizer: PASSED **");
        else
            $display("** rational_normalizer: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
